/* sv/sqhtc_pkg.sv */
`timescale 1ns / 1ps
package sqhtc_pkg;
    localparam logic [2:0] VERDICT_STACK      = 3'd0;
    localparam logic [2:0] VERDICT_QUEUE      = 3'd1;
    localparam logic [2:0] VERDICT_HEAP       = 3'd2;
    localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd3;
    localparam logic [2:0] VERDICT_NOT_SURE   = 3'd4;
    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef logic [2:0] verdict_t;

    // heap unit request from the top level
    typedef struct packed {
        logic start;
        logic remove;
    } heap_req_t;

    // heap unit status to the top level
    typedef struct packed {
        logic busy;
    } heap_sts_t;

    function automatic verdict_t verdict_of(input logic s, input logic q, input logic h);
        verdict_t r;
        r = VERDICT_NOT_SURE;
        if (s && !q && !h)
        begin
            r = VERDICT_STACK;
        end
        else if (!s && q && !h)
        begin
            r = VERDICT_QUEUE;
        end
        else if (!s && !q && h)
        begin
            r = VERDICT_HEAP;
        end
        else if (!s && !q && !h)
        begin
            r = VERDICT_IMPOSSIBLE;
        end
        return r;
    endfunction
endpackage

/* sv/sqhtc_heap.sv */
`timescale 1ns / 1ps
// Max-heap in one synchronous memory; sift up on a push, down on a removal, one level at a time.
module sqhtc_heap #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 8,
    parameter int CW         = $clog2(DEPTH + 1),
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sqhtc_pkg::heap_req_t  req,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [CW-1:0]         count,
    output sqhtc_pkg::heap_sts_t  sts,
    output logic [VALUE_BITS-1:0] top
);
    import sqhtc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UPRD  = 3'd1;
    localparam logic [2:0] S_UPCMP = 3'd2;
    localparam logic [2:0] S_LAST  = 3'd3;
    localparam logic [2:0] S_DNRD  = 3'd4;
    localparam logic [2:0] S_DNC1  = 3'd5;
    localparam logic [2:0] S_DNC2  = 3'd6;
    localparam logic [2:0] S_TOPRD = 3'd7;

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rd_data;
    logic [AW-1:0]         rd_addr;
    logic                  rd_en;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  wr_en;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [CW-1:0]         c_reg, c_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [VALUE_BITS-1:0] cv_reg, cv_next;
    logic [VALUE_BITS-1:0] top_reg, top_next;
    logic [CW:0]           child1;
    logic [CW-1:0]         parent;

    // memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    assign child1 = {idx_reg, 1'b1};
    assign parent = (idx_reg - 1'b1) >> 1;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        c_next     = c_reg;
        v_next     = v_reg;
        cv_next    = cv_reg;
        top_next   = top_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = v_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start && !req.remove)
                begin
                    v_next   = value;
                    idx_next = count;
                    n_next   = count + 1'b1;
                    state_next = S_UPRD;
                end
                else if (req.start)
                begin
                    n_next   = count - 1'b1;
                    idx_next = '0;
                    rd_en    = 1'b1;
                    rd_addr  = AW'(count - 1'b1);
                    state_next = (count == CW'(1)) ? S_TOPRD : S_LAST;
                end
            end
            S_UPRD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en = 1'b1;
                    wr_addr = '0;
                    top_next = v_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = AW'(parent);
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                wr_en = 1'b1;
                wr_addr = AW'(idx_reg);
                if (rd_data >= v_reg)
                begin
                    wr_data = v_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_data = rd_data;
                    idx_next = parent;
                    state_next = S_UPRD;
                end
            end
            S_LAST:
            begin
                v_next = rd_data;
                state_next = S_DNRD;
            end
            S_DNRD:
            begin
                if (child1 >= {1'b0, n_reg})
                begin
                    wr_en = 1'b1;
                    wr_addr = AW'(idx_reg);
                    state_next = S_TOPRD;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = AW'(child1);
                    c_next = CW'(child1);
                    state_next = S_DNC1;
                end
            end
            S_DNC1:
            begin
                cv_next = rd_data;
                if ({1'b0, c_reg} + 1'b1 < {1'b0, n_reg})
                begin
                    rd_en = 1'b1;
                    rd_addr = AW'(c_reg + 1'b1);
                    state_next = S_DNC2;
                end
                else if (rd_data <= v_reg)
                begin
                    wr_en = 1'b1;
                    wr_addr = AW'(idx_reg);
                    state_next = S_TOPRD;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = AW'(idx_reg);
                    wr_data = rd_data;
                    idx_next = c_reg;
                    state_next = S_DNRD;
                end
            end
            S_DNC2:
            begin
                wr_en = 1'b1;
                wr_addr = AW'(idx_reg);
                if (rd_data > cv_reg)
                begin
                    if (rd_data <= v_reg)
                    begin
                        state_next = S_TOPRD;
                    end
                    else
                    begin
                        wr_data = rd_data;
                        idx_next = c_reg + 1'b1;
                        state_next = S_DNRD;
                    end
                end
                else if (cv_reg <= v_reg)
                begin
                    state_next = S_TOPRD;
                end
                else
                begin
                    wr_data = cv_reg;
                    idx_next = c_reg;
                    state_next = S_DNRD;
                end
            end
            S_TOPRD:
            begin
                // refresh cached root after the write has landed
                rd_en = 1'b1;
                rd_addr = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    logic top_load_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            top_load_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            top_load_reg <= (state_reg == S_TOPRD);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        n_reg   <= n_next;
        c_reg   <= c_next;
        v_reg   <= v_next;
        cv_reg  <= cv_next;
        top_reg <= top_load_reg ? rd_data : top_next;
    end

    assign top = top_reg;
    // busy covers the root reload cycle
    assign sts.busy = (state_reg != S_IDLE) || top_load_reg;

`ifndef SYNTH
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.busy |-> !req.start) else $error("heap start while busy");
    a_up_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPRD) |=> (state_reg == S_UPCMP || state_reg == S_IDLE))
        else $error("sift up sequencing");
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TOPRD) |=> top_load_reg) else $error("root reload missed");
`endif
endmodule

/* sv/stack_queue_heap_trace_classifier_top.sv */
`timescale 1ns / 1ps
// Path: a push or removal without heap work passes S_RD, S_EXEC and S_HEAP; a removal
// that sifts the heap down waits in S_HEAP while the heap unit walks one level at a time.
// Flow: one item at a time; the next item is taken only after the result has transferred,
// so the heap sift loop sets the item time.
// Reset: counts, head, live flags, overflow and handshake clear at once;
// the three stores keep no reset and are read only where written this case.
module stack_queue_heap_trace_classifier_top #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] value,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       still_stack,
    output logic       still_queue,
    output logic       still_heap,
    output logic [2:0] verdict,
    output logic       overflowed,
    output logic       case_done
);
    import sqhtc_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_HEAP = 2'd3;

    logic [1:0]            state_reg;
    logic                  cmd_reg, last_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CW-1:0]         sc_reg, rc_reg, hc_reg;
    logic [AW-1:0]         rh_reg;
    logic [2:0]            live_reg;
    logic                  ovf_reg;
    logic                  out_valid_reg;

    logic [VALUE_BITS-1:0] stack_mem [DEPTH];
    logic [VALUE_BITS-1:0] ring_mem [DEPTH];
    logic [VALUE_BITS-1:0] stack_rd, ring_rd, heap_top;

    heap_req_t hreq;
    heap_sts_t hsts;
    logic [2:0] live_next;
    logic       ovf_next;
    logic       accept;
    logic [AW:0]   ring_sum;
    logic [AW-1:0] ring_tail;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    // wrap the tail past the last entry
    assign ring_sum  = {1'b0, rh_reg} + {1'b0, rc_reg[AW-1:0]};
    assign ring_tail = (ring_sum >= (AW+1)'(DEPTH)) ? AW'(ring_sum - (AW+1)'(DEPTH))
                                                    : AW'(ring_sum);

    // stack and ring memories: read the top and head while in S_RD, write a push in S_EXEC
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            stack_rd <= stack_mem[AW'(sc_reg - 1'b1)];
            ring_rd  <= ring_mem[rh_reg];
        end
        if (state_reg == S_EXEC && cmd_reg == CMD_PUSH)
        begin
            if (live_reg[0] && sc_reg < CW'(DEPTH))
            begin
                stack_mem[AW'(sc_reg)] <= val_reg;
            end
            if (live_reg[1] && rc_reg < CW'(DEPTH))
            begin
                ring_mem[ring_tail] <= val_reg;
            end
        end
    end

    // decide flags for the executing item
    always_comb
    begin
        live_next = live_reg;
        ovf_next  = ovf_reg;
        hreq.start  = 1'b0;
        hreq.remove = cmd_reg;
        if (cmd_reg == CMD_PUSH)
        begin
            if ((live_reg[0] && sc_reg == CW'(DEPTH)) || (live_reg[1] && rc_reg == CW'(DEPTH))
                || (live_reg[2] && hc_reg == CW'(DEPTH)))
            begin
                ovf_next = 1'b1;
            end
            hreq.start = live_reg[2] && hc_reg < CW'(DEPTH);
        end
        else
        begin
            if (live_reg[0] && (sc_reg == '0 || stack_rd != val_reg))
            begin
                live_next[0] = 1'b0;
            end
            if (live_reg[1] && (rc_reg == '0 || ring_rd != val_reg))
            begin
                live_next[1] = 1'b0;
            end
            if (live_reg[2] && (hc_reg == '0 || heap_top != val_reg))
            begin
                live_next[2] = 1'b0;
            end
            hreq.start = live_next[2];
        end
        if (state_reg != S_EXEC)
        begin
            hreq.start = 1'b0;
        end
    end

    sqhtc_heap #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS), .CW(CW), .AW(AW)) u_heap (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .value (val_reg),
        .count (hc_reg),
        .sts   (hsts),
        .top   (heap_top)
    );

    // sequence one item and hold the result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sc_reg        <= '0;
            rc_reg        <= '0;
            hc_reg        <= '0;
            rh_reg        <= '0;
            live_reg      <= 3'b111;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            still_stack   <= 1'b0;
            still_queue   <= 1'b0;
            still_heap    <= 1'b0;
            verdict       <= VERDICT_STACK;
            overflowed    <= 1'b0;
            case_done     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    live_reg <= live_next;
                    ovf_reg  <= ovf_next;
                    if (cmd_reg == CMD_PUSH)
                    begin
                        if (live_reg[0] && sc_reg < CW'(DEPTH))
                        begin
                            sc_reg <= sc_reg + 1'b1;
                        end
                        if (live_reg[1] && rc_reg < CW'(DEPTH))
                        begin
                            rc_reg <= rc_reg + 1'b1;
                        end
                        if (hreq.start)
                        begin
                            hc_reg <= hc_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (live_next[0])
                        begin
                            sc_reg <= sc_reg - 1'b1;
                        end
                        if (live_next[1])
                        begin
                            rc_reg <= rc_reg - 1'b1;
                            rh_reg <= (rh_reg == AW'(DEPTH - 1)) ? '0 : rh_reg + 1'b1;
                        end
                        if (hreq.start)
                        begin
                            hc_reg <= hc_reg - 1'b1;
                        end
                    end
                    state_reg <= S_HEAP;
                end
                S_HEAP:
                begin
                    if (!hsts.busy)
                    begin
                        still_stack   <= live_reg[0];
                        still_queue   <= live_reg[1];
                        still_heap    <= live_reg[2];
                        verdict       <= verdict_of(live_reg[0], live_reg[1], live_reg[2]);
                        overflowed    <= ovf_reg;
                        case_done     <= last_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (last_reg)
                        begin
                            sc_reg   <= '0;
                            rc_reg   <= '0;
                            hc_reg   <= '0;
                            rh_reg   <= '0;
                            live_reg <= 3'b111;
                            ovf_reg  <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // capture the item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            val_reg  <= VALUE_BITS'(value);
            last_reg <= last;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("accepted while busy");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sc_reg <= CW'(DEPTH)) && (rc_reg <= CW'(DEPTH)) && (hc_reg <= CW'(DEPTH)))
        else $error("count beyond depth");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HEAP && !hsts.busy && last_reg) |=> (live_reg == 3'b111 && !ovf_reg))
        else $error("case not cleared");
`endif
endmodule
